// ----- rtl/sfpp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sfpp_pkg;

  localparam int MAX_KEYS     = 8;
  localparam int COLUMN_BITS  = 12;
  localparam int ROW_BITS     = 16;
  localparam int FC_BITS      = 13;
  localparam int OUT_COL_BITS = 24;

  localparam int IDX_W  = $clog2(MAX_KEYS);
  localparam int CNT_W  = $clog2(MAX_KEYS + 1);
  // product kept one bit wider than the column, bit 0 drops in the halving
  localparam int PROD_W = OUT_COL_BITS + 1;
  localparam int OPA_W  = COLUMN_BITS + 1;

  localparam logic [FC_BITS-1:0] FC_RESET = FC_BITS'(4096);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_RD_A,
    ST_RD_B,
    ST_MUL,
    ST_EMIT
  } sfpp_state_t;

  typedef struct packed {
    logic             capture;
    logic             emit_echo;
    logic             echo_last;
    logic             rd_a;
    logic             rd_b;
    logic             mul;
    logic             emit_pair;
    logic             pair_last;
    logic             clear_keys;
    logic [IDX_W-1:0] pair_addr;
  } sfpp_cmd_t;

  typedef struct packed {
    logic             out_free;
    logic             fin;
    logic             pairs_due;
    logic [CNT_W-1:0] key_count;
  } sfpp_status_t;

endpackage

`default_nettype wire

// ----- rtl/sfpp_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface sfpp_in_if import sfpp_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [ROW_BITS-1:0]    entry_row;
  logic [COLUMN_BITS-1:0] entry_column;
  logic                   final_entry;

  modport source (output valid, output entry_row, output entry_column,
                  output final_entry, input ready);
  modport sink   (input valid, input entry_row, input entry_column,
                  input final_entry, output ready);
endinterface

interface sfpp_out_if import sfpp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [ROW_BITS-1:0]     out_row;
  logic [OUT_COL_BITS-1:0] out_column;
  logic                    is_product;
  logic                    entry_flagged;
  logic                    last_result;

  modport source (output valid, output out_row, output out_column,
                  output is_product, output entry_flagged,
                  output last_result, input ready);
  modport sink   (input valid, input out_row, input out_column,
                  input is_product, input entry_flagged,
                  input last_result, output ready);
endinterface

`default_nettype wire

// ----- rtl/sfpp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfpp_ctrl
  import sfpp_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire sfpp_status_t stat,
  output sfpp_cmd_t         cmd
);

  sfpp_state_t      state, state_next;
  logic [IDX_W-1:0] pi, pi_next;
  logic [IDX_W-1:0] pj, pj_next;
  logic [CNT_W-1:0] cnt_m1;
  logic             j_at_end;
  logic             last_pair;

  assign cnt_m1    = stat.key_count - CNT_W'(1);
  assign j_at_end  = (CNT_W'(pj) == cnt_m1);
  assign last_pair = j_at_end && (CNT_W'(pi) == cnt_m1 - CNT_W'(1));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (stat.out_free) state_next = stat.pairs_due ? ST_RD_A : ST_IDLE;
      end
      ST_RD_A: state_next = ST_RD_B;
      ST_RD_B: state_next = ST_MUL;
      ST_MUL:  state_next = ST_EMIT;
      ST_EMIT: begin
        if (stat.out_free) state_next = last_pair ? ST_IDLE : ST_RD_A;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    pi_next = pi;
    pj_next = pj;
    unique case (state)
      ST_UPDATE: begin
        pi_next = '0;
        pj_next = IDX_W'(1);
      end
      ST_EMIT: begin
        if (stat.out_free && !last_pair) begin
          if (j_at_end) begin
            pi_next = pi + IDX_W'(1);
            pj_next = pi + IDX_W'(2);
          end else begin
            pj_next = pj + IDX_W'(1);
          end
        end
      end
      default: begin
        pi_next = pi;
        pj_next = pj;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_UPDATE: begin
        cmd.emit_echo  = stat.out_free;
        cmd.echo_last  = !stat.pairs_due;
        cmd.clear_keys = stat.out_free && stat.fin && !stat.pairs_due;
      end
      ST_RD_A: begin
        cmd.rd_a      = 1'b1;
        cmd.pair_addr = pi;
      end
      ST_RD_B: begin
        cmd.rd_b      = 1'b1;
        cmd.pair_addr = pj;
      end
      ST_MUL: cmd.mul = 1'b1;
      ST_EMIT: begin
        cmd.emit_pair  = stat.out_free;
        cmd.pair_last  = last_pair;
        cmd.clear_keys = stat.out_free && last_pair;
      end
      default: cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pi    <= '0;
      pj    <= '0;
    end else begin
      state <= state_next;
      pi    <= pi_next;
      pj    <= pj_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sfpp_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sfpp_dp
  import sfpp_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire sfpp_cmd_t               cmd,
  output sfpp_status_t                 stat,
  input  wire logic                    fc_we,
  input  wire logic [FC_BITS-1:0]      fc_wdata,
  input  wire logic [ROW_BITS-1:0]     in_row,
  input  wire logic [COLUMN_BITS-1:0]  in_col,
  input  wire logic                    in_fin,
  input  wire logic                    out_ready,
  output logic                         out_valid,
  output logic [ROW_BITS-1:0]          out_row,
  output logic [OUT_COL_BITS-1:0]      out_column,
  output logic                         out_product,
  output logic                         out_flagged,
  output logic                         out_last
);

  logic [FC_BITS-1:0]     fc;
  logic [ROW_BITS-1:0]    row_r;
  logic [COLUMN_BITS-1:0] col_r;
  logic                   fin_r;

  logic [COLUMN_BITS-1:0] key_col [MAX_KEYS];
  logic [ROW_BITS-1:0]    key_row [MAX_KEYS];
  logic [CNT_W-1:0]       key_count;

  logic [MAX_KEYS-1:0] hit;
  logic [MAX_KEYS-1:0] raise;
  logic                found;
  logic                in_range;
  logic                can_insert;
  logic                do_insert;
  logic                flag;
  logic [CNT_W-1:0]    count_after;
  logic [IDX_W-1:0]    ins_idx;

  logic [COLUMN_BITS-1:0]  rd_col;
  logic [ROW_BITS-1:0]     rd_row;
  logic [COLUMN_BITS-1:0]  a_col;
  logic [ROW_BITS-1:0]     a_row;
  logic [COLUMN_BITS-1:0]  lo_col;
  logic [COLUMN_BITS-1:0]  hi_col;
  logic [ROW_BITS-1:0]     pair_row;
  logic [OPA_W-1:0]        mul_a;
  logic [PROD_W-1:0]       mul_b;
  logic [OPA_W+PROD_W-1:0] mul_full;
  logic [PROD_W-1:0]       prod;
  logic [OUT_COL_BITS-1:0] diff;
  logic [OUT_COL_BITS-1:0] pair_col;

  // key match, one comparator per entry; an out-of-range column updates nothing
  always_comb begin
    for (int k = 0; k < MAX_KEYS; k++) begin
      hit[k]   = (CNT_W'(k) < key_count) && (key_col[k] == col_r);
      raise[k] = in_range && hit[k] && (row_r > key_row[k]);
    end
  end

  assign found       = |hit;
  assign in_range    = (FC_BITS'(col_r) < fc);
  assign can_insert  = (key_count < CNT_W'(MAX_KEYS));
  assign do_insert   = in_range && !found && can_insert;
  assign flag        = !in_range || (!found && !can_insert);
  assign count_after = key_count + CNT_W'(do_insert);
  assign ins_idx     = key_count[IDX_W-1:0];

  assign stat.out_free  = !out_valid || out_ready;
  assign stat.fin       = fin_r;
  assign stat.pairs_due = fin_r && (count_after >= CNT_W'(2));
  assign stat.key_count = key_count;

  // single read port for the pair walk
  assign rd_col = key_col[cmd.pair_addr];
  assign rd_row = key_row[cmd.pair_addr];

  // (lo+1)*(2n-lo), kept modulo 2^PROD_W
  assign mul_a    = OPA_W'(lo_col) + OPA_W'(1);
  assign mul_b    = PROD_W'({fc, 1'b0}) - PROD_W'(lo_col);
  assign mul_full = (OPA_W+PROD_W)'(mul_a) * (OPA_W+PROD_W)'(mul_b);
  assign pair_col = prod[PROD_W-1:1] + diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      fc <= FC_RESET;
    end else if (fc_we) begin
      fc <= fc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      row_r <= in_row;
      col_r <= in_col;
      fin_r <= in_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_echo) begin
      for (int k = 0; k < MAX_KEYS; k++) begin
        if (raise[k]) key_row[k] <= row_r;
      end
      if (do_insert) begin
        key_col[ins_idx] <= col_r;
        key_row[ins_idx] <= row_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cmd.clear_keys) begin
      key_count <= '0;
    end else if (cmd.emit_echo) begin
      key_count <= count_after;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      a_col <= rd_col;
      a_row <= rd_row;
    end
    if (cmd.rd_b) begin
      lo_col   <= (a_col < rd_col) ? a_col : rd_col;
      hi_col   <= (a_col < rd_col) ? rd_col : a_col;
      pair_row <= (a_row > rd_row) ? a_row : rd_row;
    end
    if (cmd.mul) begin
      prod <= mul_full[PROD_W-1:0];
      diff <= OUT_COL_BITS'(hi_col) - OUT_COL_BITS'(lo_col) - OUT_COL_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_echo || cmd.emit_pair) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_echo) begin
      out_row     <= row_r;
      out_column  <= OUT_COL_BITS'(col_r);
      out_product <= 1'b0;
      out_flagged <= flag;
      out_last    <= cmd.echo_last;
    end else if (cmd.emit_pair) begin
      out_row     <= pair_row;
      out_column  <= pair_col;
      out_product <= 1'b1;
      out_flagged <= 1'b0;
      out_last    <= cmd.pair_last;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/sparse_feature_pair_product.sv -----
// An entry is taken only in IDLE; its echo word is registered in UPDATE, and
//   a final entry adds one product word per pair, K*(K-1)/2 of them for K kept
//   columns (the pair walk reads one store entry per cycle and goes through one
//   multiplier); a busy output register holds back either kind of word.
// Reset (rst, synchronous, active high): store emptied, feature_count = 4096,
//   output word register empty.
`timescale 1ns / 1ps
`default_nettype none

module sparse_feature_pair_product
  import sfpp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  sfpp_in_if.sink                 entry_in,
  sfpp_out_if.source              result_out,
  input  wire logic               cfg_we,
  input  wire logic [FC_BITS-1:0] cfg_wdata
);

  // Control/status between the sequencer and the datapath.
  sfpp_cmd_t    cmd;
  sfpp_status_t stat;

  // Sequencer: takes one entry in IDLE, emits its echo in UPDATE, and on a
  // final entry with two or more kept columns walks every pair i<j in
  // first-seen order (read a, read b, multiply, emit).
  sfpp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (entry_in.valid),
    .in_ready (entry_in.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Datapath: column store with per-entry match, pair operand registers,
  // product column arithmetic and the one-deep output word register.
  sfpp_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .fc_we       (cfg_we),
    .fc_wdata    (cfg_wdata),
    .in_row      (entry_in.entry_row),
    .in_col      (entry_in.entry_column),
    .in_fin      (entry_in.final_entry),
    .out_ready   (result_out.ready),
    .out_valid   (result_out.valid),
    .out_row     (result_out.out_row),
    .out_column  (result_out.out_column),
    .out_product (result_out.is_product),
    .out_flagged (result_out.entry_flagged),
    .out_last    (result_out.last_result)
  );

  // store never holds more than its capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    stat.key_count <= CNT_W'(MAX_KEYS))
    else $error("key count above capacity");

  // a word is loaded only when the output register is free or draining
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_echo || cmd.emit_pair) |-> stat.out_free)
    else $error("output word overwritten");

  // the pair walk reads only kept entries, and only with two or more kept
  a_pair_addr: assert property (@(posedge clk) disable iff (rst)
    (cmd.rd_a || cmd.rd_b) |->
      ((CNT_W'(cmd.pair_addr) < stat.key_count) && (stat.key_count >= CNT_W'(2))))
    else $error("pair read outside kept columns");

  // an echo that is not the last word starts the pair walk at once
  a_walk_start: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_echo && !cmd.echo_last) |=> cmd.rd_a)
    else $error("pair walk did not start after final echo");

endmodule

`default_nettype wire
